// ===== hw/rtl/gbsp_pkg.sv =====
package gbsp_pkg;

   localparam int unsigned DATA_W  = 8;
   localparam int unsigned EVENT_W = 5;
   localparam int unsigned VALUE_W = 24;
   localparam int unsigned INDEX_W = 8;

   // event codes
   typedef enum logic [EVENT_W-1:0] {
      EV_BAD_SIG      = 5'd0,
      EV_VERSION      = 5'd1,
      EV_SCR_WIDTH    = 5'd2,
      EV_SCR_HEIGHT   = 5'd3,
      EV_SCR_FLAGS    = 5'd4,
      EV_BG_INDEX     = 5'd5,
      EV_ASPECT       = 5'd6,
      EV_GLOBAL_COLOR = 5'd7,
      EV_IMG_LEFT     = 5'd8,
      EV_IMG_TOP      = 5'd9,
      EV_IMG_WIDTH    = 5'd10,
      EV_IMG_HEIGHT   = 5'd11,
      EV_IMG_FLAGS    = 5'd12,
      EV_LOCAL_COLOR  = 5'd13,
      EV_LZW_SIZE     = 5'd14,
      EV_IMG_DATA     = 5'd15,
      EV_CHAIN_END    = 5'd16,
      EV_GCE_FLAGS    = 5'd17,
      EV_GCE_DELAY    = 5'd18,
      EV_TRANSP_INDEX = 5'd19,
      EV_GCE_TERM     = 5'd20,
      EV_COMMENT_BYTE = 5'd21,
      EV_APP_ID_BYTE  = 5'd22,
      EV_APP_DATA     = 5'd23,
      EV_TRAILER      = 5'd24,
      EV_UNKNOWN_SEP  = 5'd25,
      EV_UNKNOWN_EXT  = 5'd26,
      EV_PLAIN_TEXT   = 5'd27
   } event_type;

   // payload kinds of a sub-block chain
   localparam logic [1:0] KIND_IMAGE   = 2'd0;
   localparam logic [1:0] KIND_COMMENT = 2'd1;
   localparam logic [1:0] KIND_APP     = 2'd2;

   localparam logic [DATA_W-1:0] SIG_G = 8'h47;
   localparam logic [DATA_W-1:0] SIG_I = 8'h49;
   localparam logic [DATA_W-1:0] SIG_F = 8'h46;

   localparam logic [DATA_W-1:0] SEP_IMAGE     = 8'h2C;
   localparam logic [DATA_W-1:0] SEP_EXTENSION = 8'h21;
   localparam logic [DATA_W-1:0] SEP_TRAILER   = 8'h3B;

   localparam logic [DATA_W-1:0] LBL_GCE     = 8'hF9;
   localparam logic [DATA_W-1:0] LBL_COMMENT = 8'hFE;
   localparam logic [DATA_W-1:0] LBL_PLAIN   = 8'h01;
   localparam logic [DATA_W-1:0] LBL_APP     = 8'hFF;

   localparam logic [DATA_W-1:0] GCE_SIZE    = 8'd4;
   localparam logic [DATA_W-1:0] APP_ID_SIZE = 8'd11;

   typedef struct packed {
      event_type            event_res;
      logic [VALUE_W-1:0]   value;
      logic [INDEX_W-1:0]   index;
      logic                 warn;
      logic                 stopped;
   } result_type;

endpackage

// ===== hw/rtl/gbsp_ifs.sv =====
interface gbsp_req_if import gbsp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface gbsp_rsp_if import gbsp_pkg::*; ();
   logic               valid;
   logic               ready;
   event_type          event_res;
   logic [VALUE_W-1:0] value;
   logic [INDEX_W-1:0] index;
   logic               warn;
   logic               stopped;

   modport source (output valid, output event_res, output value, output index,
                   output warn, output stopped, input ready);
   modport sink   (input valid, input event_res, input value, input index,
                   input warn, input stopped, output ready);
endinterface

// ===== hw/rtl/gif_block_structure_parser_top.sv =====
// Channel   Port      Dir  Payload
// --------  --------  ---  ----------------------------------------------
// request   req_chan  in   data_byte[7:0]
// response  rsp_chan  out  event_res[4:0] value[23:0] index[7:0] warn stopped
//
// One byte per cycle sustained while responses are taken; a byte that yields a
// response passes the input register, then the response register, before it
// is valid on rsp_chan.
// The per-byte parse step is combinational logic on the walker state.
// Synchronous reset returns the walker to the signature check.
// A stalled response holds the pipe; the input register still takes one
// byte, which then waits there until the response is taken.
module gif_block_structure_parser_top
   import gbsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   gbsp_req_if.sink   req_chan,
   gbsp_rsp_if.source rsp_chan
);

   logic              in_valid_ff;
   logic [DATA_W-1:0] in_byte_ff;
   logic              out_valid_ff;
   result_type        out_ff;
   logic              advance;
   logic              emit;
   result_type        result;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   gbsp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .emit      (emit),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= emit;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.data_byte;
      end
      if (advance && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.event_res = out_ff.event_res;
   assign rsp_chan.value     = out_ff.value;
   assign rsp_chan.index     = out_ff.index;
   assign rsp_chan.warn      = out_ff.warn;
   assign rsp_chan.stopped   = out_ff.stopped;

endmodule

// ===== hw/rtl/gbsp_core.sv =====
module gbsp_core
   import gbsp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [DATA_W-1:0] data_byte,
   output logic              emit,
   output result_type        result
);

   typedef enum logic [3:0] {
      PH_HDR, PH_SCR, PH_GPAL, PH_SEP, PH_IMG, PH_LPAL, PH_LZW,
      PH_SUBLEN, PH_SUBDATA, PH_LABEL, PH_GCE, PH_APPSIZE, PH_APPID
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic [7:0]   pos_ff, pos_in;
   logic [23:0]  asm_ff, asm_in;
   logic [8:0]   pal_left_ff, pal_left_in;
   logic [7:0]   pal_num_ff, pal_num_in;
   logic [7:0]   sub_left_ff, sub_left_in;
   logic [1:0]   kind_ff, kind_in;
   logic [7:0]   flags_ff, flags_in;
   logic         halted_ff, halted_in;

   always_comb begin
      logic [7:0]  b;
      logic [7:0]  pos_inc;
      logic [23:0] asm_shift;
      logic [23:0] asm_hi;
      logic [7:0]  sig_byte;
      logic [7:0]  hdr_flags;
      logic [8:0]  left_dec;
      logic [7:0]  sub_dec;

      b         = data_byte;
      pos_inc   = pos_ff + 8'd1;
      asm_shift = {asm_ff[15:0], b};
      asm_hi    = asm_ff | {8'd0, b, 8'd0};
      left_dec  = pal_left_ff - 9'd1;
      sub_dec   = sub_left_ff - 8'd1;
      sig_byte  = (pos_ff == 8'd0) ? SIG_G : ((pos_ff == 8'd1) ? SIG_I : SIG_F);
      hdr_flags = (pos_ff == 8'd0) ? 8'd0 : flags_ff;
      if (pos_ff < 8'd3 && b != sig_byte) begin
         hdr_flags[0] = 1'b1;
      end

      phase_in    = phase_ff;
      pos_in      = pos_ff;
      asm_in      = asm_ff;
      pal_left_in = pal_left_ff;
      pal_num_in  = pal_num_ff;
      sub_left_in = sub_left_ff;
      kind_in     = kind_ff;
      flags_in    = flags_ff;
      halted_in   = halted_ff;

      emit             = 1'b0;
      result.event_res = EV_BAD_SIG;
      result.value     = {16'd0, b};
      result.index     = '0;
      result.warn      = 1'b0;
      result.stopped   = 1'b0;

      if (!halted_ff) begin
         unique case (phase_ff)
            PH_HDR: begin
               asm_in   = asm_shift;
               flags_in = hdr_flags;
               if (pos_inc < 8'd6) begin
                  pos_in = pos_inc;
               end else begin
                  pos_in       = '0;
                  emit         = 1'b1;
                  result.value = asm_shift;
                  if (hdr_flags[0]) begin
                     result.event_res = EV_BAD_SIG;
                     result.stopped   = 1'b1;
                  end else begin
                     result.event_res = EV_VERSION;
                     flags_in         = '0;
                     phase_in         = PH_SCR;
                  end
               end
            end
            PH_SCR: begin
               pos_in = pos_inc;
               case (pos_ff)
                  8'd0, 8'd2: asm_in = {16'd0, b};
                  8'd1, 8'd3: begin
                     emit             = 1'b1;
                     result.event_res = (pos_ff == 8'd1) ? EV_SCR_WIDTH : EV_SCR_HEIGHT;
                     result.value     = asm_hi;
                  end
                  8'd4: begin
                     flags_in         = b;
                     emit             = 1'b1;
                     result.event_res = EV_SCR_FLAGS;
                  end
                  8'd5: begin
                     emit             = 1'b1;
                     result.event_res = EV_BG_INDEX;
                  end
                  default: begin
                     pos_in           = '0;
                     emit             = 1'b1;
                     result.event_res = EV_ASPECT;
                     if (flags_ff[7]) begin
                        pal_left_in = 9'd2 << flags_ff[2:0];
                        pal_num_in  = '0;
                        phase_in    = PH_GPAL;
                     end else begin
                        phase_in = PH_SEP;
                     end
                  end
               endcase
            end
            PH_GPAL, PH_LPAL: begin
               asm_in = asm_shift;
               if (pos_inc < 8'd3) begin
                  pos_in = pos_inc;
               end else begin
                  pos_in           = '0;
                  pal_num_in       = pal_num_ff + 8'd1;
                  pal_left_in      = left_dec;
                  emit             = 1'b1;
                  result.value     = asm_shift;
                  result.index     = pal_num_ff;
                  result.event_res = (phase_ff == PH_GPAL) ? EV_GLOBAL_COLOR
                                                           : EV_LOCAL_COLOR;
                  if (left_dec == 9'd0) begin
                     phase_in = (phase_ff == PH_GPAL) ? PH_SEP : PH_LZW;
                  end
               end
            end
            PH_SEP: begin
               pos_in = '0;
               if (b == SEP_IMAGE) begin
                  phase_in = PH_IMG;
               end else if (b == SEP_EXTENSION) begin
                  phase_in = PH_LABEL;
               end else begin
                  emit             = 1'b1;
                  result.stopped   = 1'b1;
                  result.event_res = (b == SEP_TRAILER) ? EV_TRAILER : EV_UNKNOWN_SEP;
               end
            end
            PH_IMG: begin
               pos_in = pos_inc;
               if (pos_ff < 8'd8) begin
                  if (!pos_ff[0]) begin
                     asm_in = {16'd0, b};
                  end else begin
                     emit             = 1'b1;
                     result.value     = asm_hi;
                     result.event_res = event_type'(EV_IMG_LEFT + {3'd0, pos_ff[2:1]});
                  end
               end else begin
                  pos_in           = '0;
                  flags_in         = b;
                  emit             = 1'b1;
                  result.event_res = EV_IMG_FLAGS;
                  if (b[7]) begin
                     pal_left_in = 9'd2 << b[2:0];
                     pal_num_in  = '0;
                     phase_in    = PH_LPAL;
                  end else begin
                     phase_in = PH_LZW;
                  end
               end
            end
            PH_LZW: begin
               kind_in          = KIND_IMAGE;
               phase_in         = PH_SUBLEN;
               pos_in           = '0;
               emit             = 1'b1;
               result.event_res = EV_LZW_SIZE;
            end
            PH_SUBLEN: begin
               if (b == 8'd0) begin
                  phase_in         = PH_SEP;
                  emit             = 1'b1;
                  result.event_res = EV_CHAIN_END;
                  result.value     = {22'd0, kind_ff};
               end else begin
                  sub_left_in = b;
                  pos_in      = '0;
                  phase_in    = PH_SUBDATA;
               end
            end
            PH_SUBDATA: begin
               pos_in      = pos_inc;
               sub_left_in = sub_dec;
               if (sub_dec == 8'd0) begin
                  phase_in = PH_SUBLEN;
                  pos_in   = '0;
               end
               emit         = 1'b1;
               result.index = pos_ff;
               case (kind_ff)
                  KIND_IMAGE:   result.event_res = EV_IMG_DATA;
                  KIND_COMMENT: result.event_res = EV_COMMENT_BYTE;
                  default:      result.event_res = EV_APP_DATA;
               endcase
            end
            PH_LABEL: begin
               pos_in = '0;
               if (b == LBL_GCE) begin
                  phase_in = PH_GCE;
               end else if (b == LBL_COMMENT) begin
                  kind_in  = KIND_COMMENT;
                  phase_in = PH_SUBLEN;
               end else if (b == LBL_APP) begin
                  phase_in = PH_APPSIZE;
               end else begin
                  emit             = 1'b1;
                  result.stopped   = 1'b1;
                  result.event_res = (b == LBL_PLAIN) ? EV_PLAIN_TEXT : EV_UNKNOWN_EXT;
               end
            end
            PH_GCE: begin
               pos_in = pos_inc;
               case (pos_ff)
                  8'd0: flags_in = {7'd0, b != GCE_SIZE};
                  8'd1: begin
                     emit             = 1'b1;
                     result.event_res = EV_GCE_FLAGS;
                     result.warn      = flags_ff[0];
                  end
                  8'd2: asm_in = {16'd0, b};
                  8'd3: begin
                     emit             = 1'b1;
                     result.event_res = EV_GCE_DELAY;
                     result.value     = asm_hi;
                  end
                  8'd4: begin
                     emit             = 1'b1;
                     result.event_res = EV_TRANSP_INDEX;
                  end
                  default: begin
                     pos_in           = '0;
                     phase_in         = PH_SEP;
                     emit             = 1'b1;
                     result.event_res = EV_GCE_TERM;
                     result.warn      = (b != 8'd0);
                  end
               endcase
            end
            PH_APPSIZE: begin
               flags_in = {7'd0, b != APP_ID_SIZE};
               pos_in   = '0;
               phase_in = PH_APPID;
            end
            PH_APPID: begin
               pos_in = pos_inc;
               if (pos_inc >= APP_ID_SIZE) begin
                  kind_in  = KIND_APP;
                  phase_in = PH_SUBLEN;
                  pos_in   = '0;
               end
               emit             = 1'b1;
               result.event_res = EV_APP_ID_BYTE;
               result.index     = pos_ff;
               result.warn      = flags_ff[0];
            end
            default: halted_in = 1'b1;
         endcase
         if (emit && result.stopped) begin
            halted_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR;
         pos_ff      <= '0;
         asm_ff      <= '0;
         pal_left_ff <= '0;
         pal_num_ff  <= '0;
         sub_left_ff <= '0;
         kind_ff     <= '0;
         flags_ff    <= '0;
         halted_ff   <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         asm_ff      <= asm_in;
         pal_left_ff <= pal_left_in;
         pal_num_ff  <= pal_num_in;
         sub_left_ff <= sub_left_in;
         kind_ff     <= kind_in;
         flags_ff    <= flags_in;
         halted_ff   <= halted_in;
      end
   end

endmodule

// ===== hw/rtl/gbsp_checker.sv =====
module gbsp_checker
   import gbsp_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [EVENT_W-1:0] rsp_event_res,
   input logic [VALUE_W-1:0] rsp_value,
   input logic [INDEX_W-1:0] rsp_index,
   input logic               rsp_warn,
   input logic               rsp_stopped
);

   logic stop_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_stopped) begin
         stop_seen_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_value) && $stable(rsp_index))
      else $error("response changed while stalled");

   a_silent_after_stop: assert property (@(posedge clock) disable iff (reset)
      stop_seen_ff |-> !rsp_valid)
      else $error("response after parse stopped");

   a_stop_events: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stopped |->
         rsp_event_res == EV_BAD_SIG || rsp_event_res == EV_TRAILER ||
         rsp_event_res == EV_UNKNOWN_SEP || rsp_event_res == EV_UNKNOWN_EXT ||
         rsp_event_res == EV_PLAIN_TEXT)
      else $error("stop flag on a non-terminal event");

   a_warn_events: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_warn |->
         rsp_event_res == EV_GCE_FLAGS || rsp_event_res == EV_GCE_TERM ||
         rsp_event_res == EV_APP_ID_BYTE)
      else $error("warning on an unexpected event");

   a_index_events: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index != '0 |->
         rsp_event_res == EV_GLOBAL_COLOR || rsp_event_res == EV_LOCAL_COLOR ||
         rsp_event_res == EV_IMG_DATA || rsp_event_res == EV_COMMENT_BYTE ||
         rsp_event_res == EV_APP_ID_BYTE || rsp_event_res == EV_APP_DATA)
      else $error("nonzero index on an unindexed event");

endmodule

bind gif_block_structure_parser_top gbsp_checker u_gbsp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_event_res (rsp_chan.event_res),
   .rsp_value     (rsp_chan.value),
   .rsp_index     (rsp_chan.index),
   .rsp_warn      (rsp_chan.warn),
   .rsp_stopped   (rsp_chan.stopped)
);

// ===== dv/tb_gif_block_structure_parser_top.sv =====
module tb_gif_block_structure_parser_top
   import gbsp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [3:0] {
      WALK_HEADER,
      WALK_SCREEN,
      WALK_GPAL,
      WALK_SEP,
      WALK_IMAGE,
      WALK_LPAL,
      WALK_LZW,
      WALK_SUBLEN,
      WALK_SUBDATA,
      WALK_LABEL,
      WALK_GCE,
      WALK_APPSIZE,
      WALK_APPID
   } walk_phase_type;

   class gif_event_scoreboard;
      walk_phase_type phase;
      logic [7:0]  byte_pos;
      logic [23:0] assembly;
      logic [8:0]  pal_left;
      logic [7:0]  pal_num;
      logic [7:0]  sub_left;
      logic [1:0]  kind;
      logic [7:0]  flags;
      bit          halted;
      result_type  pending_events[$];
      int unsigned mismatches;

      function new();
         phase = WALK_HEADER;
         byte_pos = '0;
         assembly = '0;
         pal_left = '0;
         pal_num = '0;
         sub_left = '0;
         kind = '0;
         flags = '0;
         halted = 0;
         mismatches = 0;
      endfunction

      task report(string msg);
         $display("%0t mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      function void push_event(event_type ev, logic [23:0] v, logic [7:0] idx,
                               logic w, logic s);
         result_type r;
         r.event_res = ev;
         r.value = v;
         r.index = idx;
         r.warn = w;
         r.stopped = s;
         pending_events.push_back(r);
         if (s) halted = 1;
      endfunction

      function void start_chain(logic [1:0] k);
         kind = k;
         phase = WALK_SUBLEN;
         byte_pos = '0;
      endfunction

      function void start_palette(logic [7:0] f, walk_phase_type ph);
         pal_left = 9'd2 << f[2:0];
         pal_num = '0;
         byte_pos = '0;
         phase = ph;
      endfunction

      function void palette_byte(logic [7:0] b, event_type ev, walk_phase_type nxt);
         logic [7:0] num;
         assembly = {assembly[15:0], b};
         byte_pos++;
         if (byte_pos < 3) return;
         byte_pos = '0;
         num = pal_num;
         pal_num++;
         pal_left--;
         if (pal_left == 0) phase = nxt;
         push_event(ev, assembly, num, 1'b0, 1'b0);
      endfunction

      function void note_byte(logic [7:0] b);
         logic [7:0] pos;
         logic [7:0] sig;
         if (halted) return;
         case (phase)
            WALK_HEADER: begin
               if (byte_pos == 0) flags = '0;
               sig = (byte_pos == 0) ? SIG_G : (byte_pos == 1) ? SIG_I : SIG_F;
               if (byte_pos < 3 && b != sig) flags[0] = 1'b1;
               assembly = {assembly[15:0], b};
               byte_pos++;
               if (byte_pos == 6) begin
                  byte_pos = '0;
                  if (flags[0]) begin
                     push_event(EV_BAD_SIG, assembly, 8'd0, 1'b0, 1'b1);
                  end else begin
                     flags = '0;
                     phase = WALK_SCREEN;
                     push_event(EV_VERSION, assembly, 8'd0, 1'b0, 1'b0);
                  end
               end
            end
            WALK_SCREEN: begin
               pos = byte_pos;
               byte_pos++;
               case (pos)
                  8'd0, 8'd2: assembly = 24'(b);
                  8'd1: push_event(EV_SCR_WIDTH, {8'h00, b, assembly[7:0]}, 8'd0, 1'b0, 1'b0);
                  8'd3: push_event(EV_SCR_HEIGHT, {8'h00, b, assembly[7:0]}, 8'd0, 1'b0, 1'b0);
                  8'd4: begin
                     flags = b;
                     push_event(EV_SCR_FLAGS, 24'(b), 8'd0, 1'b0, 1'b0);
                  end
                  8'd5: push_event(EV_BG_INDEX, 24'(b), 8'd0, 1'b0, 1'b0);
                  default: begin
                     byte_pos = '0;
                     if (flags[7]) start_palette(flags, WALK_GPAL);
                     else phase = WALK_SEP;
                     push_event(EV_ASPECT, 24'(b), 8'd0, 1'b0, 1'b0);
                  end
               endcase
            end
            WALK_GPAL: palette_byte(b, EV_GLOBAL_COLOR, WALK_SEP);
            WALK_SEP: begin
               byte_pos = '0;
               if (b == SEP_IMAGE) phase = WALK_IMAGE;
               else if (b == SEP_EXTENSION) phase = WALK_LABEL;
               else if (b == SEP_TRAILER) push_event(EV_TRAILER, 24'(b), 8'd0, 1'b0, 1'b1);
               else push_event(EV_UNKNOWN_SEP, 24'(b), 8'd0, 1'b0, 1'b1);
            end
            WALK_IMAGE: begin
               pos = byte_pos;
               byte_pos++;
               if (pos < 8) begin
                  if (!pos[0]) assembly = 24'(b);
                  else push_event(event_type'(EV_IMG_LEFT + pos[2:1]),
                                  {8'h00, b, assembly[7:0]}, 8'd0, 1'b0, 1'b0);
               end else begin
                  byte_pos = '0;
                  flags = b;
                  if (b[7]) start_palette(b, WALK_LPAL);
                  else phase = WALK_LZW;
                  push_event(EV_IMG_FLAGS, 24'(b), 8'd0, 1'b0, 1'b0);
               end
            end
            WALK_LPAL: palette_byte(b, EV_LOCAL_COLOR, WALK_LZW);
            WALK_LZW: begin
               start_chain(KIND_IMAGE);
               push_event(EV_LZW_SIZE, 24'(b), 8'd0, 1'b0, 1'b0);
            end
            WALK_SUBLEN: begin
               if (b == 0) begin
                  phase = WALK_SEP;
                  push_event(EV_CHAIN_END, 24'(kind), 8'd0, 1'b0, 1'b0);
               end else begin
                  sub_left = b;
                  byte_pos = '0;
                  phase = WALK_SUBDATA;
               end
            end
            WALK_SUBDATA: begin
               pos = byte_pos;
               byte_pos++;
               sub_left--;
               if (sub_left == 0) begin
                  phase = WALK_SUBLEN;
                  byte_pos = '0;
               end
               push_event(kind == KIND_IMAGE ? EV_IMG_DATA :
                          kind == KIND_COMMENT ? EV_COMMENT_BYTE : EV_APP_DATA,
                          24'(b), pos, 1'b0, 1'b0);
            end
            WALK_LABEL: begin
               byte_pos = '0;
               if (b == LBL_GCE) phase = WALK_GCE;
               else if (b == LBL_COMMENT) start_chain(KIND_COMMENT);
               else if (b == LBL_PLAIN) push_event(EV_PLAIN_TEXT, 24'(b), 8'd0, 1'b0, 1'b1);
               else if (b == LBL_APP) phase = WALK_APPSIZE;
               else push_event(EV_UNKNOWN_EXT, 24'(b), 8'd0, 1'b0, 1'b1);
            end
            WALK_GCE: begin
               pos = byte_pos;
               byte_pos++;
               case (pos)
                  8'd0: flags = (b != GCE_SIZE) ? 8'd1 : 8'd0;
                  8'd1: push_event(EV_GCE_FLAGS, 24'(b), 8'd0, flags[0], 1'b0);
                  8'd2: assembly = 24'(b);
                  8'd3: push_event(EV_GCE_DELAY, {8'h00, b, assembly[7:0]}, 8'd0, 1'b0, 1'b0);
                  8'd4: push_event(EV_TRANSP_INDEX, 24'(b), 8'd0, 1'b0, 1'b0);
                  default: begin
                     byte_pos = '0;
                     phase = WALK_SEP;
                     push_event(EV_GCE_TERM, 24'(b), 8'd0, b != 0, 1'b0);
                  end
               endcase
            end
            WALK_APPSIZE: begin
               flags = (b != APP_ID_SIZE) ? 8'd1 : 8'd0;
               byte_pos = '0;
               phase = WALK_APPID;
            end
            WALK_APPID: begin
               pos = byte_pos;
               byte_pos++;
               if (byte_pos >= 11) start_chain(KIND_APP);
               push_event(EV_APP_ID_BYTE, 24'(b), pos, flags[0], 1'b0);
            end
            default: halted = 1;
         endcase
      endfunction

      task check_event(result_type got);
         result_type want;
         if (pending_events.size() == 0) begin
            report($sformatf("response ev %0d value %06h with nothing pending",
                             got.event_res, got.value));
            return;
         end
         want = pending_events.pop_front();
         if (got.event_res !== want.event_res)
            report($sformatf("event_res %0d, want %0d", got.event_res, want.event_res));
         if (got.value !== want.value)
            report($sformatf("ev %0d value %06h, want %06h", want.event_res, got.value,
                             want.value));
         if (got.index !== want.index)
            report($sformatf("ev %0d index %0d, want %0d", want.event_res, got.index,
                             want.index));
         if (got.warn !== want.warn)
            report($sformatf("ev %0d warn %b, want %b", want.event_res, got.warn, want.warn));
         if (got.stopped !== want.stopped)
            report($sformatf("ev %0d stopped %b, want %b", want.event_res, got.stopped,
                             want.stopped));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   gbsp_req_if req_if();
   gbsp_rsp_if rsp_if();

   gif_event_scoreboard sb = new();

   logic [7:0]  gif_file[$];
   int unsigned send_idle_pct = 13;
   int unsigned recv_idle_pct = 50;

   always #5 clock = ~clock;

   gif_block_structure_parser_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial begin
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      rsp_if.ready = 1'b0;
   end

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : monitor
      result_type seen;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen.event_res = rsp_if.event_res;
            seen.value = rsp_if.value;
            seen.index = rsp_if.index;
            seen.warn = rsp_if.warn;
            seen.stopped = rsp_if.stopped;
            sb.check_event(seen);
         end
         if (req_if.valid && req_if.ready) sb.note_byte(req_if.data_byte);
      end
   end

   function void put(logic [7:0] b);
      gif_file.push_back(b);
   endfunction

   // biased toward the field extremes
   function logic [7:0] any_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function void put_chain(bit with_max);
      int unsigned n;
      int unsigned len;
      n = $urandom_range(0, 3) + with_max;
      for (int k = 0; k < n; k++) begin
         if (with_max && k == 0) len = 255;
         else if ($urandom_range(0, 29) == 0) len = 255;
         else len = $urandom_range(1, 12);
         put(8'(len));
         repeat (len) put(any_byte());
      end
      put(8'h00);
   endfunction

   function void put_image(logic [7:0] f, bit with_max);
      put(SEP_IMAGE);
      repeat (8) put(any_byte());
      put(f);
      if (f[7]) repeat (3 * (2 << f[2:0])) put(any_byte());
      put(any_byte());
      put_chain(with_max);
   endfunction

   function void put_gce();
      put(SEP_EXTENSION);
      put(LBL_GCE);
      put(($urandom_range(0, 3) == 0) ? any_byte() : GCE_SIZE);
      repeat (4) put(any_byte());
      put(($urandom_range(0, 3) == 0) ? any_byte() : 8'h00);
   endfunction

   function void put_extension_chain(logic [7:0] lbl);
      put(SEP_EXTENSION);
      put(lbl);
      if (lbl == LBL_APP) begin
         put(($urandom_range(0, 3) == 0) ? any_byte() : APP_ID_SIZE);
         repeat (11) put(any_byte());
      end
      put_chain(1'b0);
   endfunction

   function void build_gif_file();
      logic [7:0] b;
      // signature, version, screen with extremes, two-colour global palette
      put(SIG_G); put(SIG_I); put(SIG_F);
      put(8'h38); put(8'h39); put(8'h61);
      put(8'h00); put(8'h00); put(8'hFF); put(8'hFF);
      put(8'h80); put(8'hFF); put(8'h00);
      put(8'hFF); put(8'hFF); put(8'hFF); put(8'h00); put(8'h00); put(8'h00);
      // empty comment: chain terminator only
      put(SEP_EXTENSION); put(LBL_COMMENT); put(8'h00);

      // 64-entry local palette and a 255-byte sub-block
      put_image(8'hFD, 1'b1);
      while (gif_file.size() < 740) begin
         case ($urandom_range(0, 3))
            0: put_image({1'($urandom), 4'($urandom), 3'($urandom_range(0, 2))}, 1'b0);
            1: put_gce();
            2: put_extension_chain(LBL_COMMENT);
            default: put_extension_chain(LBL_APP);
         endcase
      end

      case ($urandom_range(0, 3))
         0: put(SEP_TRAILER);
         1: begin
            do b = 8'($urandom);
            while (b inside {SEP_IMAGE, SEP_EXTENSION, SEP_TRAILER});
            put(b);
         end
         2: begin
            do b = 8'($urandom);
            while (b inside {LBL_GCE, LBL_COMMENT, LBL_PLAIN, LBL_APP});
            put(SEP_EXTENSION);
            put(b);
         end
         default: begin
            put(SEP_EXTENSION);
            put(LBL_PLAIN);
         end
      endcase
      // walker has stopped: these must produce nothing
      repeat (6) put(8'($urandom));

      // now and then a broken signature, which ends the walk at byte six
      if ($urandom_range(0, 19) == 0)
         gif_file[$urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));
   endfunction

   task send_byte(logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task drain();
      req_if.valid <= 1'b0;
      while (sb.pending_events.size() != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned n;
      build_gif_file();
      n = gif_file.size();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int i = 0; i < n; i++) begin
         if (i == n / 3) begin
            drain();
            send_idle_pct = 50;
            recv_idle_pct = 13;
         end else if (i == 2 * n / 3) begin
            drain();
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_byte(gif_file[i]);
      end
      drain();
      repeat (10) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending_events.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
